// ----- hw/rtl/dmd_pkg.sv -----
// Shared types and constants for the dual-mode message deframer.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package dmd_pkg;

    // Function codes of an input word.
    localparam logic [1:0] FUNC_BYTE = 2'd0;
    localparam logic [1:0] FUNC_TAKE = 2'd1;
    localparam logic [1:0] FUNC_PREV = 2'd2;
    localparam logic [1:0] FUNC_NOP  = 2'd3;

    // Error codes reported with a result word.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_BIN_LEN = 2'd1;
    localparam logic [1:0] ERR_ASCII   = 2'd2;

    // Framing characters.
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] BIN_FLAG   = 8'h80;

    // Result of the framing logic for one word.
    typedef struct packed {
        logic       store_valid;
        logic [6:0] store_pos;
        logic [7:0] store_byte;
        logic       frame_done;
        logic [7:0] frame_header;
        logic [1:0] error_code;
        logic       echo_valid;
        logic [7:0] echo_byte;
    } t_frame_res;

    // Result of the slot ring for one word.
    typedef struct packed {
        logic [1:0] write_slot;
        logic       msg_valid;
        logic [1:0] msg_slot;
        logic [7:0] pending_count;
    } t_queue_res;

endpackage

`default_nettype wire

// ----- hw/rtl/dual_mode_message_deframer_unit.sv -----
// Top level of the dual-mode message deframer: input register, framing
// logic, slot ring and result register. Depends on dmd_pkg, dmd_deframer
// and dmd_msg_queue.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+---------------------------
//   in       | input     | i_in_valid / o_in_stall  | i_func, i_rx_byte
//   out      | output    | o_out_valid / i_out_stall| o_out_* (twelve fields)
//   cfg      | input     | i_cfg_we                 | i_cfg_wdata (echo enable)
//
// An accepted word is loaded into the input register; once the result register
// can advance, it is carried through the framing logic and the slot ring into
// the result register, where its result word becomes valid.
// One word is accepted every cycle while the output side does not stall.
// A stall on the output holds the result register and then the input register.
// Synchronous active-low reset empties both registers and returns to hunting;
// echo enable resets to one.
`default_nettype none

module dual_mode_message_deframer_unit #(
    parameter int MSG_BYTES = 64,
    parameter int NUM_SLOTS = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_func,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_out_store_valid,
    output logic [1:0]      o_out_store_slot,
    output logic [6:0]      o_out_store_pos,
    output logic [7:0]      o_out_store_byte,
    output logic            o_out_frame_done,
    output logic [7:0]      o_out_frame_header,
    output logic [1:0]      o_out_error_code,
    output logic            o_out_echo_valid,
    output logic [7:0]      o_out_echo_byte,
    output logic            o_out_msg_valid,
    output logic [1:0]      o_out_msg_slot,
    output logic [7:0]      o_out_pending_count
);

    logic                r_echo_en;
    logic                r_s1_valid;
    logic [1:0]          r_s1_func;
    logic [7:0]          r_s1_byte;
    logic                r_out_valid;
    dmd_pkg::t_frame_res r_frame;
    dmd_pkg::t_queue_res r_queue;

    logic                out_adv;
    logic                s1_load;
    logic                step;
    logic                byte_step;
    logic                finish;
    dmd_pkg::t_frame_res frame_res;
    dmd_pkg::t_queue_res queue_res;

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_adv;
    assign s1_load    = !r_s1_valid || out_adv;
    assign step       = r_s1_valid && out_adv;
    assign byte_step  = step && (r_s1_func == dmd_pkg::FUNC_BYTE);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_echo_en <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_s1_func <= i_func;
            r_s1_byte <= i_rx_byte;
        end
    end

    dmd_deframer #(
        .MSG_BYTES (MSG_BYTES)
    ) u_deframer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (byte_step),
        .i_byte        (r_s1_byte),
        .i_echo_enable (r_echo_en),
        .o_res         (frame_res),
        .o_finish      (finish)
    );

    dmd_msg_queue #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_func   (r_s1_func),
        .i_finish (finish),
        .o_res    (queue_res)
    );

    // Result register; framing fields apply only to received bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_frame <= (r_s1_func == dmd_pkg::FUNC_BYTE) ? frame_res : '0;
            r_queue <= queue_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_store_valid   = r_frame.store_valid;
    assign o_out_store_slot    = r_queue.write_slot;
    assign o_out_store_pos     = r_frame.store_pos;
    assign o_out_store_byte    = r_frame.store_byte;
    assign o_out_frame_done    = r_frame.frame_done;
    assign o_out_frame_header  = r_frame.frame_header;
    assign o_out_error_code    = r_frame.error_code;
    assign o_out_echo_valid    = r_frame.echo_valid;
    assign o_out_echo_byte     = r_frame.echo_byte;
    assign o_out_msg_valid     = r_queue.msg_valid;
    assign o_out_msg_slot      = r_queue.msg_slot;
    assign o_out_pending_count = r_queue.pending_count;

endmodule

`default_nettype wire

// ----- hw/rtl/dmd_deframer.sv -----
// Framing state machine: hunts for frame starts and reports payload writes,
// completions, errors and echo. Depends on dmd_pkg.
`default_nettype none

module dmd_deframer #(
    parameter int MSG_BYTES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_echo_enable,
    output dmd_pkg::t_frame_res    o_res,
    output logic                   o_finish
);

    localparam int CW = $clog2(MSG_BYTES + 1);

    localparam logic [1:0] ST_HUNT  = 2'd0;
    localparam logic [1:0] ST_LEN   = 2'd1;
    localparam logic [1:0] ST_BIN   = 2'd2;
    localparam logic [1:0] ST_ASCII = 2'd3;

    logic [1:0]    r_hunt, n_hunt;
    logic          r_mode, n_mode;
    logic [7:0]    r_len, n_len;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] count_inc;

    assign count_inc = r_count + CW'(1);

    // Next state and result for one received byte.
    always_comb begin
        n_hunt   = r_hunt;
        n_mode   = r_mode;
        n_len    = r_len;
        n_count  = r_count;
        o_finish = 1'b0;
        o_res    = '0;
        unique case (r_hunt)
            ST_HUNT: begin
                if (i_byte == dmd_pkg::CHAR_HASH) begin
                    n_mode  = 1'b0;
                    n_count = '0;
                    n_hunt  = ST_ASCII;
                end else if (i_byte == dmd_pkg::CHAR_COLON) begin
                    n_mode  = 1'b1;
                    n_count = '0;
                    n_hunt  = ST_LEN;
                end
            end
            ST_LEN: begin
                n_len = i_byte;
                if ({1'b0, i_byte} < 9'(MSG_BYTES)) begin
                    n_hunt = ST_BIN;
                end else begin
                    o_res.error_code = dmd_pkg::ERR_BIN_LEN;
                    n_hunt = ST_HUNT;
                end
            end
            ST_BIN: begin
                n_count            = count_inc;
                o_res.store_valid  = 1'b1;
                o_res.store_pos    = 7'(count_inc);
                o_res.store_byte   = i_byte;
                // A zero length still completes on the first payload byte.
                if (9'(count_inc) >= {1'b0, r_len}) begin
                    o_finish           = 1'b1;
                    o_res.frame_done   = 1'b1;
                    o_res.frame_header = r_len | dmd_pkg::BIN_FLAG;
                    n_hunt             = ST_HUNT;
                end
            end
            ST_ASCII: begin
                if (i_byte == dmd_pkg::CHAR_CR) begin
                    n_hunt = ST_ASCII;
                end else if (r_count >= CW'(MSG_BYTES)) begin
                    // Overflow discards the frame, even on a line feed.
                    o_res.error_code = dmd_pkg::ERR_ASCII;
                    n_hunt = ST_HUNT;
                end else begin
                    n_count           = count_inc;
                    o_res.store_valid = 1'b1;
                    o_res.store_pos   = 7'(count_inc);
                    o_res.store_byte  = i_byte;
                    if (i_byte == dmd_pkg::CHAR_LF) begin
                        o_finish           = 1'b1;
                        o_res.frame_done   = 1'b1;
                        o_res.frame_header = 8'(count_inc);
                        n_hunt             = ST_HUNT;
                    end
                end
            end
            default: begin
                n_hunt = ST_HUNT;
            end
        endcase
        // Echo follows the mode as updated by this byte.
        if (i_echo_enable && !n_mode) begin
            o_res.echo_valid = 1'b1;
            o_res.echo_byte  = i_byte;
        end
    end

    // Framing state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunt  <= ST_HUNT;
            r_mode  <= 1'b0;
            r_len   <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_hunt  <= n_hunt;
            r_mode  <= n_mode;
            r_len   <= n_len;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dmd_msg_queue.sv -----
// Ring of message slots: write slot, read slot and pending count, with the
// take and previous requests. Depends on dmd_pkg.
`default_nettype none

module dmd_msg_queue #(
    parameter int NUM_SLOTS = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [1:0]        i_func,
    input  wire logic              i_finish,
    output dmd_pkg::t_queue_res    o_res
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

    logic [SW-1:0] r_wr, n_wr;
    logic [SW-1:0] r_rd, n_rd;
    logic [7:0]    r_pend, n_pend;
    logic [SW-1:0] wr_next, rd_next, rd_prev;

    assign wr_next = (r_wr == LAST_SLOT) ? '0 : r_wr + SW'(1);
    assign rd_next = (r_rd == LAST_SLOT) ? '0 : r_rd + SW'(1);
    assign rd_prev = (r_rd == '0) ? LAST_SLOT : r_rd - SW'(1);

    // Slot bookkeeping for one word.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_pend = r_pend;
        o_res = '0;
        o_res.write_slot = 2'(r_wr);
        unique case (i_func)
            dmd_pkg::FUNC_BYTE: begin
                // Completion overwrites unread slots; the count saturates.
                if (i_finish) begin
                    n_wr = wr_next;
                    if (r_pend != 8'hFF) begin
                        n_pend = r_pend + 8'd1;
                    end
                end
            end
            dmd_pkg::FUNC_TAKE: begin
                if (r_pend != 8'd0) begin
                    n_pend          = r_pend - 8'd1;
                    n_rd            = rd_next;
                    o_res.msg_valid = 1'b1;
                    o_res.msg_slot  = 2'(r_rd);
                end
            end
            dmd_pkg::FUNC_PREV: begin
                o_res.msg_valid = 1'b1;
                o_res.msg_slot  = 2'(rd_prev);
            end
            dmd_pkg::FUNC_NOP: begin
                n_pend = r_pend;
            end
        endcase
        o_res.pending_count = n_pend;
    end

    // Ring registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_pend <= '0;
        end else if (i_step) begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_pend <= n_pend;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dmd_checker.sv -----
// Port-level checks for the dual-mode message deframer, attached to the top
// level by the bind statement at the end. Depends on dmd_pkg.
`default_nettype none

module dmd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_out_store_valid,
    input wire logic [1:0] o_out_store_slot,
    input wire logic [6:0] o_out_store_pos,
    input wire logic [7:0] o_out_store_byte,
    input wire logic       o_out_frame_done,
    input wire logic [7:0] o_out_frame_header,
    input wire logic [1:0] o_out_error_code,
    input wire logic       o_out_echo_valid,
    input wire logic [7:0] o_out_echo_byte,
    input wire logic       o_out_msg_valid,
    input wire logic [1:0] o_out_msg_slot,
    input wire logic [7:0] o_out_pending_count
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word present after reset");

    // A stalled result word holds its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_store_pos)
            && $stable(o_out_frame_header) && $stable(o_out_pending_count)
            && $stable(o_out_msg_slot) && $stable(o_out_store_byte)
            && $stable(o_out_store_slot) && $stable(o_out_echo_byte))
        else $error("stalled result word changed");

    // A completion always comes with the write of its last payload byte.
    a_done_with_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_frame_done |-> o_out_store_valid)
        else $error("frame completion without payload write");

    // An error word writes nothing to the store.
    a_error_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_error_code != dmd_pkg::ERR_NONE)
            |-> !o_out_store_valid && !o_out_frame_done)
        else $error("store write together with an error");

    // A returned slot never comes from a received byte.
    a_msg_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_msg_valid |-> !o_out_store_valid && !o_out_echo_valid)
        else $error("message slot returned together with byte results");

endmodule

bind dual_mode_message_deframer_unit dmd_checker u_dmd_checker (.*);

`default_nettype wire
